@@ hdl/sorted_set_priority_queue_assert.svh @@
// ----------------------------------------------------------------------------
// sorted_set_priority_queue assertion macros
// Shorthand for clocked properties, with reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_SET_PRIORITY_QUEUE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SSQ_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_set_priority_queue: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SSQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_set_priority_queue: next-cycle check failed");

`endif

@@ hdl/ssq_pkg.sv @@
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared constants, codes and types of the sorted-set priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ssq_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_WIDTH = 32;
   localparam int PORT_KEY_W = 32;
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   typedef logic [KEY_WIDTH-1:0] key_type;
   typedef logic [CNT_W-1:0]     count_type;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_POP    = 2'd2,
      KIND_SEARCH = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_DUP  = 2'd1,
      ST_FULL = 2'd2,
      ST_MISS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_CMP  = 2'd1,
      S_UPD  = 2'd2,
      S_OUT  = 2'd3
   } state_type;

   typedef struct packed {
      logic capture;
      logic ins;
      logic del;
      logic pop;
   } cell_cmd_type;

endpackage

`default_nettype wire

@@ hdl/sorted_set_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_set_priority_queue
// Priority queue of distinct keys kept in ascending order in a row of cells.
//
//   channel  dir  handshake              fields
//   req      in   req_valid, req_ready   kind, key
//   rsp      out  rsp_valid, rsp_ready   found, status, popped_key, min_key, is_empty, count
//
// Each item goes through these steps before the next is taken: accept the
// operand, let every cell compare against it, shift the row, then load the
// output register. The result is valid from the cycle after that load. A
// stalled rsp holds the queue in its last step until the output register
// frees. Reset empties the queue; req_ready stays low while reset is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_set_priority_queue
   import ssq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_kind,
   input  wire logic [PORT_KEY_W-1:0] req_key,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_found,
   output logic [1:0]                 rsp_status,
   output logic [PORT_KEY_W-1:0]      rsp_popped_key,
   output logic [PORT_KEY_W-1:0]      rsp_min_key,
   output logic                       rsp_is_empty,
   output logic [CNT_W-1:0]           rsp_count
);

   state_type    state_ff, state_in;
   kind_type     kind_ff, kind_in;
   key_type      key_ff, key_in;
   count_type    count_ff, count_in;
   logic         res_found_ff, res_found_in;
   status_type   res_status_ff, res_status_in;
   key_type      res_popped_ff, res_popped_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_load;
   logic         rsp_found_ff;
   status_type   rsp_status_ff;
   logic [PORT_KEY_W-1:0] rsp_popped_ff, rsp_min_ff;
   logic         rsp_empty_ff;
   count_type    rsp_count_ff;

   cell_cmd_type          cmd;
   logic [CAPACITY-1:0]   valid_vec, below_vec, equal_vec;
   key_type               key_arr [CAPACITY];
   logic                  present;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      key_type left_key, right_key;
      logic    left_below;

      assign valid_vec[i] = CNT_W'(i) < count_ff;

      if (i == 0) begin : g_first
         assign left_below = 1'b1;
         assign left_key   = key_ff;
      end else begin : g_mid
         assign left_below = below_vec[i-1];
         assign left_key   = key_arr[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = key_arr[i];
      end else begin : g_inner
         assign right_key = key_arr[i+1];
      end

      ssq_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .valid      (valid_vec[i]),
         .cmp_key    (key_ff),
         .left_below (left_below),
         .left_key   (left_key),
         .right_key  (right_key),
         .below      (below_vec[i]),
         .equal      (equal_vec[i]),
         .key        (key_arr[i])
      );
   end

   assign present = |equal_vec;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      res_popped_in = res_popped_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid) begin
               kind_in  = kind_type'(req_kind);
               key_in   = KEY_WIDTH'(req_key);
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.capture = 1'b1;
            state_in    = S_UPD;
         end
         S_UPD: begin
            res_found_in  = 1'b0;
            res_status_in = ST_DONE;
            res_popped_in = '0;
            case (kind_ff)
               KIND_INSERT: begin
                  if (present) begin
                     res_found_in  = 1'b1;
                     res_status_in = ST_DUP;
                  end else if (count_ff >= CNT_W'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     cmd.ins  = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               KIND_DELETE: begin
                  if (present) begin
                     res_found_in = 1'b1;
                     cmd.del      = 1'b1;
                     count_in     = count_ff - 1'b1;
                  end else begin
                     res_status_in = ST_MISS;
                  end
               end
               KIND_POP: begin
                  if (count_ff != '0) begin
                     res_found_in  = 1'b1;
                     res_popped_in = key_arr[0];
                     cmd.pop       = 1'b1;
                     count_in      = count_ff - 1'b1;
                  end else begin
                     res_status_in = ST_MISS;
                  end
               end
               default: begin
                  if (present) begin
                     res_found_in = 1'b1;
                  end else begin
                     res_status_in = ST_MISS;
                  end
               end
            endcase
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      res_popped_ff <= res_popped_in;
      if (rsp_load) begin
         rsp_found_ff  <= res_found_ff;
         rsp_status_ff <= res_status_ff;
         rsp_popped_ff <= PORT_KEY_W'(res_popped_ff);
         rsp_min_ff    <= (count_ff != '0) ? PORT_KEY_W'(key_arr[0]) : '0;
         rsp_empty_ff  <= (count_ff == '0);
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_popped_key = rsp_popped_ff;
   assign rsp_min_key    = rsp_min_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_count      = rsp_count_ff;

`include "sorted_set_priority_queue_assert.svh"

   `SSQ_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `SSQ_ASSERT_NEXT(a_accept_to_cmp, req_valid && req_ready, state_ff == S_CMP)
   `SSQ_ASSERT_SAME(a_empty_count, rsp_valid, rsp_is_empty == (rsp_count == '0))
   `SSQ_ASSERT_SAME(a_found_status, rsp_valid && rsp_found,
      rsp_status_ff == ST_DONE || rsp_status_ff == ST_DUP)

endmodule

`default_nettype wire

@@ hdl/ssq_cell.sv @@
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted row: holds a key, compares it with the operand and
// takes its next key from itself, its neighbors or the operand.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_cell
   import ssq_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_cmd_type cmd,
   input  wire logic         valid,
   input  wire key_type      cmp_key,
   input  wire logic         left_below,
   input  wire key_type      left_key,
   input  wire key_type      right_key,
   output logic              below,
   output logic              equal,
   output key_type           key
);

   key_type key_ff, key_in;
   logic    below_ff, equal_ff;

   always_comb begin
      key_in = key_ff;
      if (cmd.ins) begin
         if (!below_ff) begin
            key_in = left_below ? cmp_key : left_key;
         end
      end else if (cmd.del) begin
         if (!below_ff) begin
            key_in = right_key;
         end
      end else if (cmd.pop) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (cmd.capture) begin
         below_ff <= valid && (key_ff < cmp_key);
         equal_ff <= valid && (key_ff == cmp_key);
      end
   end

   assign below = below_ff;
   assign equal = equal_ff;
   assign key   = key_ff;

endmodule

`default_nettype wire
